@@ src/nlqt_pkg.sv @@
// Shared types and constants for the neighbor link-quality table.
// No dependencies.
package nlqt_pkg;

  localparam int unsigned PERMILLE   = 1000;
  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned QUOT_W     = 16;
  localparam logic [31:0] TIMEOUT_RST = 32'd768;

  typedef struct packed {
    logic [15:0]        addr;
    logic signed [7:0]  rssi;
    logic [15:0]        unique_cnt;
    logic [15:0]        dup_cnt;
    logic [15:0]        oldest_seq;
    logic [15:0]        newest_seq;
    logic [15:0]        sent;
    logic [15:0]        ratio;
    logic [31:0]        seen;
  } entry_t;

endpackage

@@ src/nlqt_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nlqt_pkg.
module nlqt_div
  import nlqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    rem;
  logic [DIVIDEND_W-1:0] q;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;

  assign trial    = {rem[DIVISOR_W-1:0], q[DIVIDEND_W-1]};
  assign quotient = q[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          q   <= {q[DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[DIVIDEND_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/neighbor_link_quality_table_unit.sv @@
// Receive: search the table; for a new word on a full table, also scan for the weakest entry;
// a known entry is updated, with a divide for its ratio; then the table is sorted, one swap at a time.
// Sweep: one pass that replaces each stale entry by the last one. Each result word is held while out_stall is high.
// Throughput: one item at a time; the next is taken after its last result is taken.
// Reset (rst, synchronous): table empty, timeout_ticks = 768, no result pending.
// Depends on nlqt_pkg and nlqt_div (radix-2 restoring divider).
module neighbor_link_quality_table_unit
  import nlqt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [15:0]        src_addr,
  input  logic signed [7:0]  rssi,
  input  logic [15:0]        seq,
  input  logic [31:0]        now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               entry_valid,
  output logic [2:0]         slot,
  output logic [15:0]        neighbor_addr,
  output logic signed [7:0]  neighbor_rssi,
  output logic [15:0]        unique_count,
  output logic [15:0]        duplicate_count,
  output logic [15:0]        sent_estimate,
  output logic [15:0]        ratio_permille,
  output logic [3:0]         entry_total,
  output logic               last_of_run
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_FIND = 15'b000000000000010,
    S_MIN  = 15'b000000000000100,
    S_NEW  = 15'b000000000001000,
    S_UPD  = 15'b000000000010000,
    S_DST  = 15'b000000000100000,
    S_DIV  = 15'b000000001000000,
    S_WB   = 15'b000000010000000,
    S_SI   = 15'b000000100000000,
    S_SJ   = 15'b000001000000000,
    S_SW   = 15'b000010000000000,
    S_SWP  = 15'b000100000000000,
    S_MOVE = 15'b001000000000000,
    S_DUMP = 15'b010000000000000,
    S_WAIT = 15'b100000000000000
  } state_t;

  state_t            state;
  entry_t            tbl [TABLE_DEPTH];
  logic [CW-1:0]     total;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     jp;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     rd_idx;
  entry_t            rd;
  entry_t            wk;
  entry_t            upd;
  entry_t            cur;
  entry_t            tmp;
  logic signed [7:0] minr;
  logic [31:0]       timeout_ticks;
  logic              op_r;
  logic [15:0]       addr_r;
  logic signed [7:0] rssi_r;
  logic [15:0]       seq_r;
  logic [31:0]       now_r;
  logic [CW-1:0]     last_idx;
  logic [15:0]       seq_diff;
  logic [15:0]       new_last;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_q;
  logic [DIVIDEND_W-1:0] dividend;

  assign last_idx = total - 1'b1;
  assign in_stall = (state != S_IDLE);
  assign seq_diff = seq_r - rd.newest_seq;
  assign new_last = (seq_diff != 16'd0 && !seq_diff[15]) ? seq_r : rd.newest_seq;
  assign dividend = DIVIDEND_W'(32'(wk.unique_cnt) * PERMILLE);
  assign div_start = (state == S_DST) && (wk.sent != 16'd0);

  always_comb begin
    case (state)
      S_UPD:   rd_idx = idx;
      S_SJ:    rd_idx = jp[IW-1:0];
      S_MOVE:  rd_idx = last_idx[IW-1:0];
      default: rd_idx = ptr[IW-1:0];
    endcase
  end

  assign rd = tbl[rd_idx];

  always_comb begin
    upd            = rd;
    upd.rssi       = rssi_r;
    upd.seen       = now_r;
    upd.newest_seq = new_last;
    upd.sent       = new_last - rd.oldest_seq + 16'd1;
    if (seq_diff == 16'd0) begin
      upd.dup_cnt = rd.dup_cnt + 16'd1;
    end else if (!seq_diff[15]) begin
      upd.unique_cnt = rd.unique_cnt + 16'd1;
    end
  end

  nlqt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (wk.sent),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op;
            addr_r <= src_addr;
            rssi_r <= rssi;
            seq_r  <= seq;
            now_r  <= now;
            ptr    <= '0;
            state  <= op ? S_SWP : S_FIND;
          end
        end
        S_FIND: begin
          if (ptr == total) begin
            if (total < CW'(TABLE_DEPTH)) begin
              idx   <= total[IW-1:0];
              total <= total + 1'b1;
              state <= S_NEW;
            end else begin
              ptr   <= '0;
              idx   <= '0;
              state <= S_MIN;
            end
          end else if (rd.addr == addr_r) begin
            idx   <= ptr[IW-1:0];
            state <= S_UPD;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_MIN: begin
          if (ptr == CW'(TABLE_DEPTH)) begin
            state <= S_NEW;
          end else begin
            if (ptr == '0 || $signed(rd.rssi) < $signed(minr)) begin
              minr <= rd.rssi;
              idx  <= ptr[IW-1:0];
            end
            ptr <= ptr + 1'b1;
          end
        end
        S_NEW: begin
          tbl[idx] <= '{addr: addr_r, rssi: rssi_r, unique_cnt: 16'd1, dup_cnt: 16'd0,
                        oldest_seq: seq_r, newest_seq: seq_r, sent: 16'd1,
                        ratio: 16'(PERMILLE), seen: now_r};
          ptr   <= '0;
          state <= S_SI;
        end
        S_UPD: begin
          wk    <= upd;
          state <= S_DST;
        end
        S_DST: begin
          if (wk.sent == 16'd0) begin
            wk.ratio <= 16'd0;
            state    <= S_WB;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            wk.ratio <= div_q;
            state    <= S_WB;
          end
        end
        S_WB: begin
          tbl[idx] <= wk;
          ptr      <= '0;
          state    <= S_SI;
        end
        S_SI: begin
          if (CW'(ptr + 1'b1) >= total) begin
            ptr   <= '0;
            state <= S_DUMP;
          end else begin
            cur   <= rd;
            jp    <= ptr + 1'b1;
            state <= S_SJ;
          end
        end
        S_SJ: begin
          if (jp == total) begin
            ptr   <= ptr + 1'b1;
            state <= S_SI;
          end else if ($signed(rd.rssi) > $signed(cur.rssi)) begin
            tbl[ptr[IW-1:0]] <= rd;
            tmp   <= rd;
            state <= S_SW;
          end else begin
            jp <= jp + 1'b1;
          end
        end
        S_SW: begin
          tbl[jp[IW-1:0]] <= cur;
          cur   <= tmp;
          jp    <= jp + 1'b1;
          state <= S_SJ;
        end
        S_SWP: begin
          if (ptr == total) begin
            ptr   <= '0;
            state <= S_DUMP;
          end else if ((now_r - rd.seen) > timeout_ticks) begin
            if (CW'(ptr + 1'b1) < total) begin
              state <= S_MOVE;
            end else begin
              total <= total - 1'b1;
            end
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_MOVE: begin
          tbl[ptr[IW-1:0]] <= rd;
          total <= total - 1'b1;
          state <= S_SWP;
        end
        S_DUMP: begin
          out_valid <= 1'b1;
          if (total == '0) begin
            entry_valid     <= 1'b0;
            slot            <= '0;
            neighbor_addr   <= '0;
            neighbor_rssi   <= '0;
            unique_count    <= '0;
            duplicate_count <= '0;
            sent_estimate   <= '0;
            ratio_permille  <= '0;
            entry_total     <= '0;
            last_of_run     <= 1'b1;
          end else begin
            entry_valid     <= 1'b1;
            slot            <= 3'(ptr);
            neighbor_addr   <= rd.addr;
            neighbor_rssi   <= rd.rssi;
            unique_count    <= rd.unique_cnt;
            duplicate_count <= rd.dup_cnt;
            sent_estimate   <= rd.sent;
            ratio_permille  <= rd.ratio;
            entry_total     <= 4'(total);
            last_of_run     <= (ptr == last_idx);
          end
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_of_run) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= S_DUMP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(TABLE_DEPTH)) else $error("entry count beyond table depth");
  a_out_only_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_WAIT) else $error("result word outside wait state");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done outside divide state");
  a_sweep_no_sort: assert property (@(posedge clk) disable iff (rst)
    (state == S_SI) |-> !op_r) else $error("sort entered on a sweep");
`endif

endmodule
